>>> sv/mvht_pkg.sv
`default_nettype none

package mvht_pkg;

    // field widths
    localparam int KIND_W   = 2;
    localparam int MAC_W    = 48;
    localparam int VLAN_W   = 12;
    localparam int PORT_W   = 14;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 11;

    // hash constants
    localparam int          HASH_SPAN = 24;
    localparam logic [31:0] HASH_MULT = 32'h009e3701;

    // record limit after reset
    localparam logic [CNT_W-1:0] RECORD_LIMIT_RST = 11'd1024;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    // one table row
    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  key;
        logic [VLAN_W-1:0] vlan;
        logic [PORT_W-1:0] port;
        logic              is_dynamic;
    } entry_t;

endpackage

`default_nettype wire

>>> sv/mac_vlan_hash_table.sv
`default_nettype none

// channel   dir  tdata (low bit up)                               tuser
// s_        in   mac_addr, vlan_id, port, is_dynamic              kind
// m_        out  old_vlan_id, old_port, old_is_dynamic, entry_count  status
// cfg_      in   write enable and 11-bit record_limit, no read-back
//
// a request goes from accept to the next accept through hash, one table read per
// way through the single read port, last way compare, write-back, then idle.
// after reset a clearing pass writes every row with s_tready low; configuration
// writes are taken throughout.
// a result waiting on m_tready does not block the next accept, only its write-back.

module mac_vlan_hash_table
    import mvht_pkg::*;
#(
    parameter int HASH_BITS = 8,
    parameter int WAYS      = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,  // mac_addr, vlan_id, port, is_dynamic
    input  wire logic [1:0]  s_tuser,  // kind

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // old_vlan_id, old_port, old_is_dynamic, entry_count
    output logic [2:0]       m_tuser,  // status

    input  wire logic        cfg_wen,
    input  wire logic [10:0] cfg_wdata
);

    localparam int DEPTH  = (1 << HASH_BITS) * WAYS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_LAST,
        S_DECIDE
    } state_t;

    state_t state_reg;

    // request registers
    logic [KIND_W-1:0] req_kind_reg;
    logic [MAC_W-1:0]  req_mac_reg;
    logic [VLAN_W-1:0] req_vlan_reg;
    logic [PORT_W-1:0] req_port_reg;
    logic              req_dyn_reg;

    // sequencer and search results
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [WAY_W-1:0]  issue_way_reg;
    logic              cmp_en_reg;
    logic [WAY_W-1:0]  cmp_way_reg;
    logic              hit_reg;
    logic [WAY_W-1:0]  hit_way_reg;
    logic              free_reg;
    logic [WAY_W-1:0]  free_way_reg;
    logic [VLAN_W-1:0] old_vlan_reg;
    logic [PORT_W-1:0] old_port_reg;
    logic              old_dyn_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  limit_reg;

    // output registers
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [VLAN_W-1:0]   out_vlan_reg;
    logic [PORT_W-1:0]   out_port_reg;
    logic                out_dyn_reg;
    logic [CNT_W-1:0]    out_count_reg;

    // table memory
    entry_t mem [DEPTH];
    entry_t mem_q_reg;

    logic [HASH_BITS-1:0] bucket;
    logic [ADDR_W-1:0]    base_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    entry_t               wr_data;

    logic                 out_free;
    logic                 dec_wr;
    logic [WAY_W-1:0]     dec_way;
    entry_t               dec_row;
    logic [STATUS_W-1:0]  dec_status;
    logic [CNT_W-1:0]     count_next;
    logic                 old_keep;
    logic                 decide_fire;

    // bucket hash of the top three key bytes
    mvht_hash #(
        .HASH_BITS (HASH_BITS)
    ) u_hash (
        .aclk    (aclk),
        .key_top (req_mac_reg[MAC_W-1 -: HASH_SPAN]),
        .bucket  (bucket)
    );

    assign base_addr = ADDR_W'(bucket * WAYS);
    assign rd_addr   = base_addr + ADDR_W'(issue_way_reg);

    assign out_free    = !m_tvalid_reg || m_tready;
    assign decide_fire = (state_reg == S_DECIDE) && out_free;

    // outcome of the request from the search results
    always_comb begin
        dec_wr             = 1'b0;
        dec_way            = hit_way_reg;
        dec_status         = ST_NOT_FOUND;
        count_next         = count_reg;
        dec_row.valid      = 1'b1;
        dec_row.key        = req_mac_reg;
        dec_row.vlan       = req_vlan_reg;
        dec_row.port       = req_port_reg;
        dec_row.is_dynamic = req_dyn_reg;
        old_keep           = 1'b0;
        case (req_kind_reg)
            KIND_INSERT: begin
                old_keep = hit_reg;
                if (hit_reg) begin
                    dec_wr     = 1'b1;
                    dec_status = ST_UPDATED;
                end else if (!free_reg || count_reg >= limit_reg) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_wr     = 1'b1;
                    dec_way    = free_way_reg;
                    count_next = count_reg + CNT_W'(1);
                    dec_status = ST_ADDED;
                end
            end
            KIND_REMOVE: begin
                old_keep = hit_reg;
                if (hit_reg) begin
                    dec_wr        = 1'b1;
                    dec_row.valid = 1'b0;
                    dec_status    = ST_REMOVED;
                    if (count_reg != '0) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            KIND_LOOKUP: begin
                old_keep = hit_reg;
                if (hit_reg) begin
                    dec_status = ST_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    // single write port: clearing pass or write-back
    always_comb begin
        if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end else begin
            wr_en   = decide_fire && dec_wr;
            wr_addr = base_addr + ADDR_W'(dec_way);
            wr_data = dec_row;
        end
    end

    // table memory with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // sequencer, search state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            issue_way_reg <= '0;
            cmp_en_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            count_reg     <= '0;
            limit_reg     <= RECORD_LIMIT_RST;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end

            cmp_en_reg  <= (state_reg == S_READ);
            cmp_way_reg <= issue_way_reg;

            // compare the way that came back from the table
            if (cmp_en_reg) begin
                if (mem_q_reg.valid && mem_q_reg.key == req_mac_reg && !hit_reg) begin
                    hit_reg      <= 1'b1;
                    hit_way_reg  <= cmp_way_reg;
                    old_vlan_reg <= mem_q_reg.vlan;
                    old_port_reg <= mem_q_reg.port;
                    old_dyn_reg  <= mem_q_reg.is_dynamic;
                end
                if (!mem_q_reg.valid && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_way_reg <= cmp_way_reg;
                end
            end

            if (m_tvalid_reg && m_tready && !decide_fire) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        req_kind_reg <= s_tuser[KIND_W-1:0];
                        req_mac_reg  <= s_tdata[MAC_W-1:0];
                        req_vlan_reg <= s_tdata[MAC_W +: VLAN_W];
                        req_port_reg <= s_tdata[MAC_W+VLAN_W +: PORT_W];
                        req_dyn_reg  <= s_tdata[MAC_W+VLAN_W+PORT_W];
                        hit_reg      <= 1'b0;
                        free_reg     <= 1'b0;
                        state_reg    <= S_HASH;
                    end
                end
                S_HASH: begin
                    issue_way_reg <= '0;
                    state_reg     <= S_READ;
                end
                S_READ: begin
                    issue_way_reg <= issue_way_reg + WAY_W'(1);
                    if (issue_way_reg == WAY_W'(WAYS - 1)) begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST: begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (out_free) begin
                        count_reg      <= count_next;
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= dec_status;
                        out_vlan_reg   <= old_keep ? old_vlan_reg : '0;
                        out_port_reg   <= old_keep ? old_port_reg : '0;
                        out_dyn_reg    <= old_keep ? old_dyn_reg : 1'b0;
                        out_count_reg  <= count_next;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_dyn_reg, out_port_reg, out_vlan_reg};

    // a new result appears only from the write-back step
    a_result_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg) && $past(aresetn))
            |-> $past(state_reg == S_DECIDE))
        else $error("result raised outside write-back");

    // the entry count moves only at write-back
    a_count_at_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && count_reg != $past(count_reg))
            |-> $past(decide_fire))
        else $error("entry count changed outside write-back");

    // an added entry raises the count by one and writes a valid row
    a_added_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (decide_fire && dec_status == ST_ADDED)
            |-> (wr_en && wr_data.valid) ##1 (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("added entry not counted or not written");

    // no table write while idle or searching
    a_write_window: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_CLEAR || state_reg == S_DECIDE))
        else $error("table write outside clearing or write-back");

endmodule

`default_nettype wire

>>> sv/mvht_hash.sv
`default_nettype none

module mvht_hash
    import mvht_pkg::*;
#(
    parameter int HASH_BITS = 8
) (
    input  wire logic                 aclk,
    input  wire logic [HASH_SPAN-1:0] key_top,
    output logic      [HASH_BITS-1:0] bucket
);

    logic [31:0]          prod;
    logic [HASH_BITS-1:0] bucket_reg;

    // product kept modulo 2^32
    assign prod = 32'(key_top * HASH_MULT);

    // registered bucket select
    always_ff @(posedge aclk) begin
        bucket_reg <= prod[HASH_SPAN-HASH_BITS +: HASH_BITS];
    end

    assign bucket = bucket_reg;

endmodule

`default_nettype wire
